// ----- rtl/sfd_pkg.sv -----
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types and constants for the serial frame deframer.
// ----------------------------------------------------------------------------
package sfd_pkg;

    // Frame delimiter bytes
    localparam logic [7:0] SOF_BYTE  = 8'hFF;
    localparam logic [7:0] EOF1_BYTE = 8'hFF;
    localparam logic [7:0] EOF2_BYTE = 8'hFE;

    // Configuration register indexes and reset values
    localparam logic [7:0]  CFG_IDLE_LIMIT  = 8'd0;
    localparam logic [7:0]  CFG_MAX_LENGTH  = 8'd1;
    localparam logic [15:0] IDLE_LIMIT_RST  = 16'd500;
    localparam logic [15:0] MAX_LENGTH_RST  = 16'd8192;

    // Input transaction kinds
    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // Result event codes
    typedef enum logic [1:0] {
        EV_BYTE   = 2'd0,
        EV_ACCEPT = 2'd1,
        EV_REJECT = 2'd2
    } t_event;

    // Deframer phase, one-hot
    typedef enum logic [8:0] {
        PH_SOF1   = 9'b000000001,
        PH_SOF2   = 9'b000000010,
        PH_CIPHER = 9'b000000100,
        PH_LEN_LO = 9'b000001000,
        PH_LEN_HI = 9'b000010000,
        PH_DATA   = 9'b000100000,
        PH_CHECK  = 9'b001000000,
        PH_EOF1   = 9'b010000000,
        PH_EOF2   = 9'b100000000
    } t_phase;

    // One result transaction
    typedef struct packed {
        t_event      evt;
        logic [7:0]  payload_byte;
        logic [15:0] payload_index;
        logic [15:0] frame_length;
    } t_result;

    // Result handed from the core to the output queue
    typedef struct packed {
        logic    valid;
        t_result res;
    } t_push;

endpackage

// ----- rtl/sfd_core.sv -----
// ----------------------------------------------------------------------------
// sfd_core
// Frame recognition state: processes one registered byte or tick per cycle
// while i_fire is high and produces at most one result transaction.
// ----------------------------------------------------------------------------
module sfd_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  logic                 i_mode,
    input  logic [7:0]           i_data_byte,
    input  logic [15:0]          i_idle_limit,
    input  logic [15:0]          i_max_length,
    output sfd_pkg::t_push       o_push
);

    sfd_pkg::t_phase r_phase, n_phase, w_eff_phase;
    logic [15:0]     r_frame_len, n_frame_len;
    logic [15:0]     r_byte_count, n_byte_count;
    logic [7:0]      r_running_sum, n_running_sum;
    logic [15:0]     r_idle_ticks, n_idle_ticks;
    logic [15:0]     w_len_full;
    logic [15:0]     w_count_inc;
    logic            w_begun;
    sfd_pkg::t_push  w_push;

    // Payload counts as begun once a byte went out or the frame is past it
    assign w_begun = ((r_phase == sfd_pkg::PH_DATA) && (r_byte_count != '0)) ||
                     (r_phase == sfd_pkg::PH_CHECK) ||
                     (r_phase == sfd_pkg::PH_EOF1)  ||
                     (r_phase == sfd_pkg::PH_EOF2);

    assign w_len_full  = {i_data_byte, r_frame_len[7:0]};
    assign w_count_inc = r_byte_count + 16'd1;

    // Next state and result
    always_comb begin
        n_phase       = r_phase;
        n_frame_len   = r_frame_len;
        n_byte_count  = r_byte_count;
        n_running_sum = r_running_sum;
        n_idle_ticks  = r_idle_ticks;
        w_eff_phase   = r_phase;
        w_push        = '0;
        w_push.res.frame_length = r_frame_len;

        if (i_fire) begin
            if (i_mode == sfd_pkg::MODE_TICK) begin
                // count idle time, saturate
                if (r_idle_ticks != '1) begin
                    n_idle_ticks = r_idle_ticks + 16'd1;
                end
            end else begin
                n_idle_ticks = '0;
                // restart search after a long gap
                if (r_idle_ticks > i_idle_limit) begin
                    if (w_begun) begin
                        w_push.valid   = 1'b1;
                        w_push.res.evt = sfd_pkg::EV_REJECT;
                    end
                    w_eff_phase = sfd_pkg::PH_SOF1;
                end

                case (w_eff_phase)
                    sfd_pkg::PH_SOF2: begin
                        if (i_data_byte == sfd_pkg::SOF_BYTE) begin
                            n_phase = sfd_pkg::PH_CIPHER;
                        end
                    end
                    sfd_pkg::PH_CIPHER: begin
                        n_phase = (i_data_byte <= 8'd1) ? sfd_pkg::PH_LEN_LO
                                                        : sfd_pkg::PH_SOF1;
                    end
                    sfd_pkg::PH_LEN_LO: begin
                        n_frame_len = {8'd0, i_data_byte};
                        n_phase     = sfd_pkg::PH_LEN_HI;
                    end
                    sfd_pkg::PH_LEN_HI: begin
                        n_frame_len = w_len_full;
                        if ((w_len_full != '0) && (w_len_full <= i_max_length)) begin
                            n_byte_count = '0;
                            n_phase      = sfd_pkg::PH_DATA;
                        end else begin
                            n_phase = sfd_pkg::PH_SOF1;
                        end
                    end
                    sfd_pkg::PH_DATA: begin
                        n_running_sum            = r_running_sum + i_data_byte;
                        w_push.valid             = 1'b1;
                        w_push.res.evt           = sfd_pkg::EV_BYTE;
                        w_push.res.payload_byte  = i_data_byte;
                        w_push.res.payload_index = r_byte_count;
                        n_byte_count             = w_count_inc;
                        if (w_count_inc >= r_frame_len) begin
                            n_phase = sfd_pkg::PH_CHECK;
                        end
                    end
                    sfd_pkg::PH_CHECK: begin
                        if (r_running_sum == i_data_byte) begin
                            n_phase = sfd_pkg::PH_EOF1;
                        end else begin
                            w_push.valid   = 1'b1;
                            w_push.res.evt = sfd_pkg::EV_REJECT;
                            n_phase        = sfd_pkg::PH_SOF1;
                        end
                    end
                    sfd_pkg::PH_EOF1: begin
                        if (i_data_byte == sfd_pkg::EOF1_BYTE) begin
                            n_phase = sfd_pkg::PH_EOF2;
                        end else begin
                            w_push.valid   = 1'b1;
                            w_push.res.evt = sfd_pkg::EV_REJECT;
                            n_phase        = sfd_pkg::PH_SOF1;
                        end
                    end
                    sfd_pkg::PH_EOF2: begin
                        w_push.valid   = 1'b1;
                        w_push.res.evt = (i_data_byte == sfd_pkg::EOF2_BYTE) ?
                                         sfd_pkg::EV_ACCEPT : sfd_pkg::EV_REJECT;
                        n_phase        = sfd_pkg::PH_SOF1;
                    end
                    default: begin
                        // wait for first header byte, clear frame counters
                        n_byte_count  = '0;
                        n_running_sum = '0;
                        n_phase = (i_data_byte == sfd_pkg::SOF_BYTE) ?
                                  sfd_pkg::PH_SOF2 : sfd_pkg::PH_SOF1;
                    end
                endcase
            end
        end
    end

    assign o_push = w_push;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= sfd_pkg::PH_SOF1;
            r_frame_len   <= '0;
            r_byte_count  <= '0;
            r_running_sum <= '0;
            r_idle_ticks  <= '0;
        end else begin
            r_phase       <= n_phase;
            r_frame_len   <= n_frame_len;
            r_byte_count  <= n_byte_count;
            r_running_sum <= n_running_sum;
            r_idle_ticks  <= n_idle_ticks;
        end
    end

    // Ticks never shrink the idle counter
    a_tick_no_shrink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && (i_mode == sfd_pkg::MODE_TICK)) |=>
            (r_idle_ticks >= $past(r_idle_ticks)))
        else $error("idle counter decreased on a tick");

    // Payload byte events only come out of the data phase
    a_byte_from_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push.valid && (w_push.res.evt == sfd_pkg::EV_BYTE)) |->
            ((r_phase == sfd_pkg::PH_DATA) && (r_byte_count < r_frame_len)))
        else $error("payload byte emitted outside data phase");

endmodule

// ----- rtl/sfd_outq.sv -----
// ----------------------------------------------------------------------------
// sfd_outq
// Two-entry result queue that decouples the deframer from the output
// handshake.
// ----------------------------------------------------------------------------
module sfd_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sfd_pkg::t_push    i_push,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_ready,
    output sfd_pkg::t_result  o_res
);

    sfd_pkg::t_result r_mem [2];
    logic             r_wr_ptr, r_rd_ptr;
    logic [1:0]       r_count, n_count;
    logic             w_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign w_pop   = o_valid && i_ready;
    assign o_res   = r_mem[r_rd_ptr];

    // Track occupancy
    always_comb begin
        n_count = r_count;
        if (i_push.valid && !w_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push.valid && w_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    // Store pushed results
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.res;
        end
    end

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

    // Never push into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push.valid)
        else $error("result pushed into full queue");

    // Occupancy agrees with the pointers
    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_count == 2'd1) |-> (r_wr_ptr != r_rd_ptr)) and
        ((r_count != 2'd1) |-> (r_wr_ptr == r_rd_ptr)))
        else $error("queue pointers disagree with occupancy");

endmodule

// ----- rtl/serial_frame_deframer.sv -----
// ----------------------------------------------------------------------------
// serial_frame_deframer
// Streaming deframer for FF FF / cipher / length / payload / checksum / FF FE
// frames, with idle-tick timeout and per-byte payload output.
// ----------------------------------------------------------------------------
// One input transaction (a received byte or an idle tick) is taken every
// cycle while the input is not stalled. Each transaction is captured in an
// input register. The frame state updates at the edge that hands it from
// that register to the core, and any result goes into a two-entry output
// queue at that same edge, from which it is presented on the output. Input
// stalls only while the output queue is full, i.e. when the consumer holds
// off taking results. With the output always ready the rate is one
// transaction per cycle. Configuration writes are taken every cycle and
// must only happen while no frame transactions are in flight.
// ----------------------------------------------------------------------------
module serial_frame_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input transactions
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_mode,
    input  logic [7:0]  i_data_byte,
    // result transactions
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_event_res,
    output logic [7:0]  o_payload_byte,
    output logic [15:0] o_payload_index,
    output logic [15:0] o_frame_length,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic             r_in_valid;
    logic             r_mode;
    logic [7:0]       r_data_byte;
    logic [15:0]      r_idle_limit;
    logic [15:0]      r_max_length;
    logic             w_fire;
    logic             w_q_full;
    sfd_pkg::t_push   w_push;
    sfd_pkg::t_result w_res;

    // Hand the registered transaction to the core when the queue has room
    assign w_fire     = r_in_valid && !w_q_full;
    assign o_in_ready = !r_in_valid || w_fire;
    assign o_cfg_ready = 1'b1;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_mode      <= i_mode;
            r_data_byte <= i_data_byte;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_limit <= sfd_pkg::IDLE_LIMIT_RST;
            r_max_length <= sfd_pkg::MAX_LENGTH_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                sfd_pkg::CFG_IDLE_LIMIT: r_idle_limit <= i_cfg_data;
                sfd_pkg::CFG_MAX_LENGTH: r_max_length <= i_cfg_data;
                default: ;
            endcase
        end
    end

    sfd_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (w_fire),
        .i_mode       (r_mode),
        .i_data_byte  (r_data_byte),
        .i_idle_limit (r_idle_limit),
        .i_max_length (r_max_length),
        .o_push       (w_push)
    );

    sfd_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_full  (w_q_full),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_res   (w_res)
    );

    assign o_event_res     = w_res.evt;
    assign o_payload_byte  = w_res.payload_byte;
    assign o_payload_index = w_res.payload_index;
    assign o_frame_length  = w_res.frame_length;

endmodule

// ----- dv/sfd_frame_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_frame_checker
// Watches the input, result and register-write channels of the deframer,
// predicts each result from the accepted transactions and compares the
// results field by field in arrival order.
// ----------------------------------------------------------------------------
module sfd_frame_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic        i_mode,
    input  logic [7:0]  i_data_byte,
    // result channel
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [1:0]  i_event_res,
    input  logic [7:0]  i_payload_byte,
    input  logic [15:0] i_payload_index,
    input  logic [15:0] i_frame_length,
    // register writes
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // status to the testbench top
    output int          o_fail_count,
    output int          o_pending
);

    // Predicted deframer state and registers
    sfd_pkg::t_phase phase_q;
    logic [15:0]     frame_len_q;
    logic [15:0]     byte_count_q;
    logic [7:0]      running_sum_q;
    logic [15:0]     idle_ticks_q;
    logic [15:0]     idle_limit_q;
    logic [15:0]     max_length_q;

    sfd_pkg::t_result expected_events[$];
    int               fail_count    = 0;
    int               pending_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    // Print one line per mismatch and count it
    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        fail_count++;
    endtask

    function automatic sfd_pkg::t_result frame_reject(input logic [15:0] len);
        sfd_pkg::t_result r;
        r              = '0;
        r.evt          = sfd_pkg::EV_REJECT;
        r.frame_length = len;
        return r;
    endfunction

    // Advance the predicted deframer by one transaction; return 1 with a result
    function automatic logic deframe_step(input logic mode, input logic [7:0] rx,
                                          output sfd_pkg::t_result res);
        logic hit;
        hit = 1'b0;
        res = '0;
        if (mode == sfd_pkg::MODE_TICK) begin
            // saturating idle counter
            if (idle_ticks_q != 16'hFFFF) begin
                idle_ticks_q = idle_ticks_q + 16'd1;
            end
        end else begin
            // restart search after a long idle, dropping a frame already under way
            if (idle_ticks_q > idle_limit_q) begin
                if ((phase_q == sfd_pkg::PH_DATA && byte_count_q != 16'd0) ||
                    phase_q == sfd_pkg::PH_CHECK ||
                    phase_q == sfd_pkg::PH_EOF1 || phase_q == sfd_pkg::PH_EOF2) begin
                    hit = 1'b1;
                    res = frame_reject(frame_len_q);
                end
                phase_q = sfd_pkg::PH_SOF1;
            end
            idle_ticks_q = '0;

            case (phase_q)
                sfd_pkg::PH_SOF2: begin
                    if (rx == sfd_pkg::SOF_BYTE) phase_q = sfd_pkg::PH_CIPHER;
                end
                sfd_pkg::PH_CIPHER: begin
                    phase_q = (rx <= 8'd1) ? sfd_pkg::PH_LEN_LO : sfd_pkg::PH_SOF1;
                end
                sfd_pkg::PH_LEN_LO: begin
                    frame_len_q = {8'h00, rx};
                    phase_q     = sfd_pkg::PH_LEN_HI;
                end
                sfd_pkg::PH_LEN_HI: begin
                    frame_len_q = {rx, frame_len_q[7:0]};
                    if (frame_len_q != 16'd0 && frame_len_q <= max_length_q) begin
                        byte_count_q = '0;
                        phase_q      = sfd_pkg::PH_DATA;
                    end else begin
                        phase_q = sfd_pkg::PH_SOF1;
                    end
                end
                sfd_pkg::PH_DATA: begin
                    running_sum_q     = running_sum_q + rx;
                    hit               = 1'b1;
                    res.evt           = sfd_pkg::EV_BYTE;
                    res.payload_byte  = rx;
                    res.payload_index = byte_count_q;
                    res.frame_length  = frame_len_q;
                    byte_count_q      = byte_count_q + 16'd1;
                    if (byte_count_q >= frame_len_q) phase_q = sfd_pkg::PH_CHECK;
                end
                sfd_pkg::PH_CHECK: begin
                    if (running_sum_q == rx) begin
                        phase_q = sfd_pkg::PH_EOF1;
                    end else begin
                        hit     = 1'b1;
                        res     = frame_reject(frame_len_q);
                        phase_q = sfd_pkg::PH_SOF1;
                    end
                end
                sfd_pkg::PH_EOF1: begin
                    if (rx == sfd_pkg::EOF1_BYTE) begin
                        phase_q = sfd_pkg::PH_EOF2;
                    end else begin
                        hit     = 1'b1;
                        res     = frame_reject(frame_len_q);
                        phase_q = sfd_pkg::PH_SOF1;
                    end
                end
                sfd_pkg::PH_EOF2: begin
                    hit              = 1'b1;
                    res.evt          = (rx == sfd_pkg::EOF2_BYTE) ? sfd_pkg::EV_ACCEPT
                                                                  : sfd_pkg::EV_REJECT;
                    res.frame_length = frame_len_q;
                    phase_q          = sfd_pkg::PH_SOF1;
                end
                default: begin
                    byte_count_q  = '0;
                    running_sum_q = '0;
                    phase_q       = (rx == sfd_pkg::SOF_BYTE) ? sfd_pkg::PH_SOF2
                                                              : sfd_pkg::PH_SOF1;
                end
            endcase
        end
        return hit;
    endfunction

    // Track every channel at the rising edge
    always @(posedge i_clk) begin
        sfd_pkg::t_result want;
        sfd_pkg::t_result got_res;
        if (!i_rst_n) begin
            phase_q       = sfd_pkg::PH_SOF1;
            frame_len_q   = '0;
            byte_count_q  = '0;
            running_sum_q = '0;
            idle_ticks_q  = '0;
            idle_limit_q  = sfd_pkg::IDLE_LIMIT_RST;
            max_length_q  = sfd_pkg::MAX_LENGTH_RST;
            expected_events.delete();
        end else begin
            // register writes
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == sfd_pkg::CFG_IDLE_LIMIT) begin
                    idle_limit_q = i_cfg_data;
                end else if (i_cfg_index == sfd_pkg::CFG_MAX_LENGTH) begin
                    max_length_q = i_cfg_data;
                end
            end

            // compare a result with the oldest prediction
            if (i_out_valid && i_out_ready) begin
                if (expected_events.size() == 0) begin
                    report_mismatch($sformatf("unexpected result, event %0d", i_event_res));
                end else begin
                    want = expected_events.pop_front();
                    if (i_event_res !== want.evt) begin
                        report_mismatch($sformatf("event %0d, want %0d",
                                                  i_event_res, want.evt));
                    end
                    if (i_payload_byte !== want.payload_byte) begin
                        report_mismatch($sformatf("payload byte %0h, want %0h",
                                                  i_payload_byte, want.payload_byte));
                    end
                    if (i_payload_index !== want.payload_index) begin
                        report_mismatch($sformatf("payload index %0d, want %0d",
                                                  i_payload_index, want.payload_index));
                    end
                    if (i_frame_length !== want.frame_length) begin
                        report_mismatch($sformatf("frame length %0d, want %0d",
                                                  i_frame_length, want.frame_length));
                    end
                end
            end

            // predict from an accepted input transaction
            if (i_in_valid && i_in_ready) begin
                if (deframe_step(i_mode, i_data_byte, got_res)) begin
                    expected_events.push_back(got_res);
                end
            end
        end
        pending_count = expected_events.size();
    end

endmodule

// ----- dv/tb_serial_frame_deframer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_serial_frame_deframer
// Drives byte and tick transactions into the deframer: a short directed run,
// then well-formed frames with random content mixed with damaged frames,
// noise and idle bursts, under several register settings and idle patterns.
// A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_serial_frame_deframer;

    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned DRAIN_CYCLES = 8;

    // How a generated frame is damaged
    typedef enum int {
        FL_NONE,
        FL_SOF2,
        FL_CIPHER,
        FL_LENGTH,
        FL_CHECKSUM,
        FL_EOF1,
        FL_EOF2,
        FL_TIMEOUT,
        FL_QUIET_TICKS
    } t_frame_flaw;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic        mode      = sfd_pkg::MODE_BYTE;
    logic [7:0]  data_byte = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  event_res;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic [15:0] frame_length;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = 8'h00;
    logic [15:0] cfg_data  = 16'h0000;

    int          fail_cnt;
    int          pend_cnt;
    int unsigned cycle_cnt      = 0;
    int unsigned items_sent     = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned cur_idle_limit = sfd_pkg::IDLE_LIMIT_RST;
    int unsigned cur_max_len    = sfd_pkg::MAX_LENGTH_RST;

    serial_frame_deframer u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_mode          (mode),
        .i_data_byte     (data_byte),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_event_res     (event_res),
        .o_payload_byte  (payload_byte),
        .o_payload_index (payload_index),
        .o_frame_length  (frame_length),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    sfd_frame_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_mode          (mode),
        .i_data_byte     (data_byte),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_event_res     (event_res),
        .i_payload_byte  (payload_byte),
        .i_payload_index (payload_index),
        .i_frame_length  (frame_length),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_cnt),
        .o_pending       (pend_cnt)
    );

    always #5 clk = ~clk;

    // Stall the result channel at random
    always @(negedge clk) begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Abort a hung run
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("[serial_frame_deframer] ERROR");
            $finish;
        end
    end

    // Present one transaction at a falling edge, hold until accepted
    task automatic send_item(input logic kind, input logic [7:0] value);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        mode      <= kind;
        data_byte <= value;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic send_ticks(input int unsigned count);
        repeat (count) send_item(sfd_pkg::MODE_TICK, 8'($urandom));
    endtask

    // Hold off input until every predicted result has arrived, then let the pipe empty
    task automatic wait_drain();
        in_valid <= 1'b0;
        while (pend_cnt != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Leaves the write valid high; the caller lowers it after the last write
    task automatic write_reg(input logic [7:0] idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic apply_setting(input int unsigned idle_limit, input int unsigned max_len,
                                 input int unsigned idle_pct, input int unsigned stall_pct);
        wait_drain();
        write_reg(sfd_pkg::CFG_IDLE_LIMIT, 16'(idle_limit));
        write_reg(sfd_pkg::CFG_MAX_LENGTH, 16'(max_len));
        cfg_valid      <= 1'b0;
        cur_idle_limit = idle_limit;
        cur_max_len    = max_len;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
    endtask

    // Build one frame with a random payload, damage it as asked, and send it
    task automatic send_frame(input int unsigned len, input t_frame_flaw flaw);
        logic [7:0]  frame_q[$];
        logic [7:0]  sum;
        logic [7:0]  pb;
        logic [15:0] len_field;
        int unsigned cut;
        int unsigned gap;
        sum       = '0;
        len_field = 16'(len);
        frame_q.push_back(sfd_pkg::SOF_BYTE);
        if (flaw == FL_SOF2) frame_q.push_back(8'($urandom_range(0, 254)));
        frame_q.push_back(sfd_pkg::SOF_BYTE);
        frame_q.push_back((flaw == FL_CIPHER) ? 8'($urandom_range(2, 255))
                                              : 8'($urandom_range(0, 1)));
        if (flaw == FL_LENGTH) begin
            len_field = (cur_max_len >= 65535 || $urandom_range(0, 1) == 0)
                        ? 16'd0 : 16'(cur_max_len + 1);
        end
        frame_q.push_back(len_field[7:0]);
        frame_q.push_back(len_field[15:8]);
        repeat (len) begin
            pb  = 8'($urandom);
            sum = sum + pb;
            frame_q.push_back(pb);
        end
        frame_q.push_back((flaw == FL_CHECKSUM) ? sum + 8'($urandom_range(1, 255)) : sum);
        frame_q.push_back((flaw == FL_EOF1) ? 8'($urandom_range(0, 254))
                                            : sfd_pkg::EOF1_BYTE);
        pb = 8'($urandom_range(0, 254));
        if (pb == sfd_pkg::EOF2_BYTE) pb = 8'hFF;
        frame_q.push_back((flaw == FL_EOF2) ? pb : sfd_pkg::EOF2_BYTE);

        // place an idle gap before some byte of the frame
        cut = $urandom_range(1, frame_q.size() - 1);
        gap = 0;
        if (flaw == FL_TIMEOUT && cur_idle_limit < 1000) begin
            gap = cur_idle_limit + 1 + $urandom_range(0, 2);
        end else if ((flaw == FL_TIMEOUT || flaw == FL_QUIET_TICKS) && cur_idle_limit != 0) begin
            gap = $urandom_range(1, (cur_idle_limit < 8) ? cur_idle_limit : 8);
        end
        foreach (frame_q[i]) begin
            if (i == cut) send_ticks(gap);
            send_item(sfd_pkg::MODE_BYTE, frame_q[i]);
        end
    endtask

    // Mostly frames, some noise bytes, idle bursts and full drains
    task automatic run_random(input int unsigned count);
        int unsigned start;
        int unsigned pick;
        int unsigned cap;
        t_frame_flaw flaw;
        start = items_sent;
        while (items_sent - start < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                cap = (cur_max_len == 0) ? 8 : ((cur_max_len < 12) ? cur_max_len : 12);
                if ($urandom_range(0, 19) == 0 && cur_max_len >= 40) begin
                    cap = (cur_max_len < 300) ? cur_max_len : 300;
                end
                flaw = ($urandom_range(0, 1) == 0) ? FL_NONE :
                       t_frame_flaw'($urandom_range(int'(FL_SOF2), int'(FL_QUIET_TICKS)));
                send_frame($urandom_range(1, cap), flaw);
            end else if (pick < 85) begin
                repeat ($urandom_range(1, 5)) send_item(sfd_pkg::MODE_BYTE, 8'($urandom));
            end else if (pick < 98) begin
                send_ticks($urandom_range(1, (cur_idle_limit < 40) ? cur_idle_limit + 3 : 40));
            end else begin
                wait_drain();
            end
        end
    endtask

    initial begin
        // reset
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: good frame, bad trailer, byte and tick extremes at reset values
        send_frame(1, FL_NONE);
        send_frame(1, FL_EOF2);
        send_item(sfd_pkg::MODE_BYTE, 8'h00);
        send_item(sfd_pkg::MODE_TICK, 8'hFF);
        send_item(sfd_pkg::MODE_BYTE, 8'hFF);
        send_item(sfd_pkg::MODE_TICK, 8'h00);

        // random phases across settings and idle patterns
        apply_setting(20, 16, 0, 0);
        run_random(300);
        apply_setting(0, 1, 51, 0);
        run_random(250);
        apply_setting(65535, 65535, 0, 51);
        run_random(250);
        apply_setting(7, 5, 11, 11);
        run_random(300);
        apply_setting(3, 0, 0, 0);
        run_random(60);
        apply_setting(1, 3, 51, 0);
        run_random(250);
        apply_setting(5, 12, 0, 51);
        run_random(250);
        apply_setting(65534, 8, 11, 11);
        run_random(250);

        // final drain and verdict
        wait_drain();
        if (fail_cnt == 0) begin
            $display("[serial_frame_deframer] OK");
        end else begin
            $display("[serial_frame_deframer] ERROR");
        end
        $finish;
    end

endmodule
